// ===== design/lmc_pkg.sv =====
// ============================================================================
// lmc_pkg
// Shared sizes, register codes and types of the local minimum counter.
// ============================================================================
`default_nettype none

package lmc_pkg;

    // Matrix limits and field widths
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int DIM_W       = 11;
    localparam int TOTAL_W     = 20;
    localparam int ENTRY_W     = VALUE_WIDTH + 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CAND_N      = 4;

    // Register codes (index = paddr[2])
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // Result kinds
    localparam logic KIND_MINIMUM = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    // One element with its position flags
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [ROW_W-1:0]              row;
        logic [COL_W-1:0]              col;
        logic                          first_row;
        logic                          first_col;
        logic                          last_row;
        logic                          last_col;
    } item_t;

    // One result item
    typedef struct packed {
        logic                          kind;
        logic [ROW_W-1:0]              row;
        logic [COL_W-1:0]              col;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [TOTAL_W-1:0]            total;
        logic                          last;
    } result_t;

endpackage

`default_nettype wire

// ===== design/lmc_ram.sv =====
// ============================================================================
// lmc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
`default_nettype none

module lmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lmc_issue.sv =====
// ============================================================================
// lmc_issue
// Raster position tracking: tags each accepted element with its position.
// ============================================================================
`default_nettype none

module lmc_issue
    import lmc_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          restart,
    input  wire logic                          take,
    input  wire logic [DIM_W-1:0]              row_count,
    input  wire logic [DIM_W-1:0]              column_count,
    input  wire logic signed [VALUE_WIDTH-1:0] element_value,
    output item_t                              item
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] rows_clamped, cols_clamped;
    logic [DIM_W-1:0] rows_m1, cols_m1;

    // Out-of-range sizes act as 1 or the maximum
    always_comb
    begin
        if (row_count == '0)
            rows_clamped = DIM_W'(1);
        else if (row_count > DIM_W'(MAX_ROWS))
            rows_clamped = DIM_W'(MAX_ROWS);
        else
            rows_clamped = row_count;

        if (column_count == '0)
            cols_clamped = DIM_W'(1);
        else if (column_count > DIM_W'(MAX_COLUMNS))
            cols_clamped = DIM_W'(MAX_COLUMNS);
        else
            cols_clamped = column_count;

        rows_m1 = rows_clamped - DIM_W'(1);
        cols_m1 = cols_clamped - DIM_W'(1);
    end

    // Tag the element
    always_comb
    begin
        item.value     = element_value;
        item.row       = row_reg;
        item.col       = col_reg;
        item.first_row = (row_reg == '0);
        item.first_col = (col_reg == '0);
        item.last_row  = (row_reg == rows_m1[ROW_W-1:0]);
        item.last_col  = (col_reg == cols_m1[COL_W-1:0]);
    end

    // Advance in raster order on each transfer
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (take)
        begin
            if (item.last_col)
            begin
                col_next = '0;
                row_next = item.last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lmc_decide.sv =====
// ============================================================================
// lmc_decide
// Decision stage: compares an element with its line-buffer entry and its
// left neighbor, writes the line buffer back and raises result candidates.
// ============================================================================
`default_nettype none

module lmc_decide
    import lmc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               restart,
    input  wire logic               take,
    input  item_t                   item_in,
    input  wire logic [ENTRY_W-1:0] mem_rdata,
    input  wire logic               room,
    output logic                    take_ready,
    output logic                    fire,
    output logic                    mem_we,
    output logic [COL_W-1:0]        mem_waddr,
    output logic [ENTRY_W-1:0]      mem_wdata,
    output result_t [CAND_N-1:0]    cand,
    output logic [CAND_N-1:0]       cand_valid
);

    // Stage register and forwarded line-buffer entry
    logic                          s1_valid_reg, s1_valid_next;
    item_t                         s1_reg;
    logic                          fwd_valid_reg, fwd_valid_next;
    logic [ENTRY_W-1:0]            fwd_data_reg, fwd_data_next;

    // Running state
    logic signed [VALUE_WIDTH-1:0] left_value_reg, left_value_next;
    logic                          left_cand_reg, left_cand_next;
    logic [TOTAL_W-1:0]            seen_reg, seen_next;

    // Deferred last-column write
    logic                          tail_pending_reg, tail_pending_next;
    logic [COL_W-1:0]              tail_addr_reg, tail_addr_next;
    logic [ENTRY_W-1:0]            tail_data_reg, tail_data_next;

    logic [ENTRY_W-1:0]            above_entry;
    logic signed [VALUE_WIDTH-1:0] above_value;
    logic                          above_flag;
    logic                          v_below_above, above_below_v;
    logic                          v_below_left, left_below_v;
    logic                          is_cand, left_lc, final_item;
    logic                          hit_above, hit_left, hit_self;
    logic                          normal_we, tail_set;
    logic [ENTRY_W-1:0]            self_entry;

    assign fire       = s1_valid_reg && room;
    assign take_ready = !s1_valid_reg || fire;

    // Neighbor compares
    always_comb
    begin
        above_entry   = fwd_valid_reg ? fwd_data_reg : mem_rdata;
        above_value   = signed'(above_entry[VALUE_WIDTH-1:0]);
        above_flag    = above_entry[ENTRY_W-1];
        v_below_above = s1_reg.value < above_value;
        above_below_v = above_value < s1_reg.value;
        v_below_left  = s1_reg.value < left_value_reg;
        left_below_v  = left_value_reg < s1_reg.value;

        is_cand    = (s1_reg.first_row || v_below_above) &&
                     (s1_reg.first_col || v_below_left);
        left_lc    = left_cand_reg && left_below_v;
        final_item = s1_reg.last_row && s1_reg.last_col;

        hit_above  = !s1_reg.first_row && above_flag && above_below_v;
        hit_left   = !s1_reg.first_col && s1_reg.last_row && left_lc;
        hit_self   = final_item && is_cand;
        self_entry = {is_cand, s1_reg.value};
    end

    // Result candidates in output order
    always_comb
    begin
        cand[0].kind  = KIND_MINIMUM;
        cand[0].row   = s1_reg.row - ROW_W'(1);
        cand[0].col   = s1_reg.col;
        cand[0].value = above_value;
        cand[0].total = seen_reg + TOTAL_W'(1);
        cand[0].last  = 1'b0;

        cand[1].kind  = KIND_MINIMUM;
        cand[1].row   = s1_reg.row;
        cand[1].col   = s1_reg.col - COL_W'(1);
        cand[1].value = left_value_reg;
        cand[1].total = seen_reg + TOTAL_W'(hit_above) + TOTAL_W'(1);
        cand[1].last  = 1'b0;

        // Self excludes both neighbor hits
        cand[2].kind  = KIND_MINIMUM;
        cand[2].row   = s1_reg.row;
        cand[2].col   = s1_reg.col;
        cand[2].value = s1_reg.value;
        cand[2].total = seen_reg + TOTAL_W'(1);
        cand[2].last  = 1'b0;

        cand[3].kind  = KIND_COUNT;
        cand[3].row   = '0;
        cand[3].col   = '0;
        cand[3].value = '0;
        cand[3].total = seen_reg + TOTAL_W'(hit_above) + TOTAL_W'(hit_left)
                        + TOTAL_W'(hit_self);
        cand[3].last  = 1'b1;

        cand_valid = {final_item, hit_self, hit_left, hit_above} &
                     {CAND_N{s1_valid_reg}};
    end

    // Line-buffer write port: left neighbor first, deferred entry when free
    always_comb
    begin
        normal_we = fire && !s1_reg.first_col && !s1_reg.last_row;
        tail_set  = fire && s1_reg.last_col && !s1_reg.last_row;
        mem_we    = normal_we || tail_pending_reg;
        if (normal_we)
        begin
            mem_waddr = s1_reg.col - COL_W'(1);
            mem_wdata = {left_lc, left_value_reg};
        end
        else
        begin
            mem_waddr = tail_addr_reg;
            mem_wdata = tail_data_reg;
        end

        tail_pending_next = tail_set || (tail_pending_reg && normal_we);
        tail_addr_next    = tail_set ? s1_reg.col : tail_addr_reg;
        tail_data_next    = tail_set ? self_entry : tail_data_reg;
    end

    // Forwarding for the entry read at this transfer, newest write first
    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        fwd_data_next  = fwd_data_reg;
        if (take)
        begin
            if (tail_set && (s1_reg.col == item_in.col))
            begin
                fwd_valid_next = 1'b1;
                fwd_data_next  = self_entry;
            end
            else if (mem_we && (mem_waddr == item_in.col))
            begin
                fwd_valid_next = 1'b1;
                fwd_data_next  = mem_wdata;
            end
            else if (tail_pending_reg && (tail_addr_reg == item_in.col))
            begin
                fwd_valid_next = 1'b1;
                fwd_data_next  = tail_data_reg;
            end
            else
            begin
                fwd_valid_next = 1'b0;
            end
        end
    end

    // Stage occupancy and running state
    always_comb
    begin
        s1_valid_next   = take ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        left_value_next = left_value_reg;
        left_cand_next  = left_cand_reg;
        seen_next       = seen_reg;
        if (restart)
        begin
            left_value_next = '0;
            left_cand_next  = 1'b0;
            seen_next       = '0;
        end
        else if (fire)
        begin
            if (final_item)
            begin
                left_value_next = '0;
                left_cand_next  = 1'b0;
                seen_next       = '0;
            end
            else
            begin
                seen_next = seen_reg + TOTAL_W'(hit_above) + TOTAL_W'(hit_left);
                if (!s1_reg.last_col)
                begin
                    left_value_next = s1_reg.value;
                    left_cand_next  = is_cand;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            left_value_reg   <= '0;
            left_cand_reg    <= 1'b0;
            seen_reg         <= '0;
            tail_pending_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
            left_value_reg   <= left_value_next;
            left_cand_reg    <= left_cand_next;
            seen_reg         <= seen_next;
            tail_pending_reg <= tail_pending_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= item_in;
        end
        fwd_data_reg  <= fwd_data_next;
        tail_addr_reg <= tail_addr_next;
        tail_data_reg <= tail_data_next;
    end

endmodule

`default_nettype wire

// ===== design/lmc_result_fifo.sv =====
// ============================================================================
// lmc_result_fifo
// Result queue: takes up to three results per cycle in order, sends one.
// ============================================================================
`default_nettype none

module lmc_result_fifo
    import lmc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  result_t [CAND_N-1:0] cand,
    input  wire logic [CAND_N-1:0] cand_valid,
    output logic                 room,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output result_t              head
);

    result_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       wr_reg, wr_next;
    logic [FIFO_AW-1:0]       rd_reg, rd_next;
    logic [FIFO_AW:0]         cnt_reg, cnt_next;
    logic [FIFO_AW-1:0]       prefix [CAND_N];
    logic [FIFO_AW:0]         n_push;
    logic                     pop;

    // Compact the valid candidates into consecutive slots
    always_comb
    begin
        n_push = '0;
        for (int k = 0; k < CAND_N; k++)
        begin
            prefix[k] = n_push[FIFO_AW-1:0];
            n_push    = n_push + (FIFO_AW+1)'(cand_valid[k]);
        end
    end

    assign room      = ({1'b0, cnt_reg} + {1'b0, n_push}) <= (FIFO_AW+2)'(FIFO_DEPTH);
    assign out_valid = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = push ? wr_reg + n_push[FIFO_AW-1:0] : wr_reg;
        rd_next  = pop ? rd_reg + FIFO_AW'(1) : rd_reg;
        cnt_next = cnt_reg + (push ? n_push : '0) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Slot writes
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAND_N; k++)
        begin
            if (push && cand_valid[k])
            begin
                slot_reg[wr_reg + prefix[k]] <= cand[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/local_minimum_counter_core.sv =====
// ============================================================================
// local_minimum_counter_core
// Counts four-neighbor local minima of a matrix streamed in raster order.
// ============================================================================
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  input    | in        | in_valid/in_ready   | element_value
//  output   | out       | out_valid/out_ready | kind, row_index, column_index,
//           |           |                     | minimum_value, minima_total,
//           |           |                     | last_result
//  config   | in        | APB psel/penable    | row_count (0x0), column_count (0x4)
//
//  One element per cycle while the decision stage can pass its results on;
//  the line-buffer read and the decision-stage load happen on one transfer.
//  Results leave a four-entry queue one per cycle while out_ready is high;
//  the decision stage holds while the queue lacks room for its results,
//  which stalls input. No clearing pass after reset: row 0 writes every
//  line-buffer entry first. A register write restarts the matrix.
// ============================================================================
`default_nettype none

module local_minimum_counter_core
    import lmc_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Element input
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] element_value,
    // Result output
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               kind,
    output logic [ROW_W-1:0]                   row_index,
    output logic [COL_W-1:0]                   column_index,
    output logic signed [VALUE_WIDTH-1:0]      minimum_value,
    output logic [TOTAL_W-1:0]                 minima_total,
    output logic                               last_result,
    // Configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [DIM_W-1:0]      row_count_reg, row_count_next;
    logic [DIM_W-1:0]      column_count_reg, column_count_next;
    logic                  cfg_write;
    logic                  take, take_ready, fire, room;
    item_t                 item;
    logic                  mem_we;
    logic [COL_W-1:0]      mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata, mem_rdata;
    result_t [CAND_N-1:0]  cand;
    logic [CAND_N-1:0]     cand_valid;
    result_t               head;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_ROW_COUNT:    row_count_next    = pwdata[DIM_W-1:0];
                REG_COLUMN_COUNT: column_count_next = pwdata[DIM_W-1:0];
                default:          row_count_next    = row_count_reg;
            endcase
        end
        case (paddr[2])
            REG_ROW_COUNT:    prdata = {{(32-DIM_W){1'b0}}, row_count_reg};
            REG_COLUMN_COUNT: prdata = {{(32-DIM_W){1'b0}}, column_count_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_W'(1);
            column_count_reg <= DIM_W'(1);
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
        end
    end

    // Input transfer
    assign in_ready = take_ready;
    assign take     = in_valid && take_ready;

    lmc_issue u_issue (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (cfg_write),
        .take          (take),
        .row_count     (row_count_reg),
        .column_count  (column_count_reg),
        .element_value (element_value),
        .item          (item)
    );

    // Previous-row line buffer: value plus pending flag per column
    lmc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (take),
        .raddr (item.col),
        .rdata (mem_rdata)
    );

    lmc_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_write),
        .take       (take),
        .item_in    (item),
        .mem_rdata  (mem_rdata),
        .room       (room),
        .take_ready (take_ready),
        .fire       (fire),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .cand       (cand),
        .cand_valid (cand_valid)
    );

    lmc_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .cand       (cand),
        .cand_valid (cand_valid),
        .room       (room),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .head       (head)
    );

    // Result fields
    assign kind          = head.kind;
    assign row_index     = head.row;
    assign column_index  = head.col;
    assign minimum_value = head.value;
    assign minima_total  = head.total;
    assign last_result   = head.last;

endmodule

`default_nettype wire
